FILE: rtl/rssg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssg_pkg
// Shared constants and types of the random subsample swap generator.
// ----------------------------------------------------------------------------
package rssg_pkg;

  localparam int FIELD_BITS = 16;
  localparam int GEN_BITS   = 31;
  localparam int MULB_BITS  = 16;
  localparam int PROD_BITS  = GEN_BITS + MULB_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [MULB_BITS-1:0] LEHMER_MUL = 16'd48271;
  localparam logic [GEN_BITS-1:0]  LEHMER_MOD = 31'h7FFF_FFFF;
  // (2^31 - 2) / 2
  localparam logic [GEN_BITS-2:0]  HALF_RANGE = 30'h3FFF_FFFF;

  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SEED      = 2'd1;

  typedef struct packed {
    logic                 en;
    logic [GEN_BITS-1:0]  a;
    logic [MULB_BITS-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] keep_index;
    logic [FIELD_BITS-1:0] swap_index;
    logic                  pair_valid;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } core_out_t;

endpackage

FILE: rtl/rssg_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssg channel interfaces
// Input, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rssg_in_if;
  logic        valid;
  logic        ready;
  logic        restart;
  logic [15:0] point_count;
  modport source(output valid, restart, point_count, input ready);
  modport sink(input valid, restart, point_count, output ready);
endinterface

interface rssg_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] keep_index;
  logic [15:0] swap_index;
  logic        pair_valid;
  logic        last;
  modport source(output valid, keep_index, swap_index, pair_valid, last, input ready);
  modport sink(input valid, keep_index, swap_index, pair_valid, last, output ready);
endinterface

interface rssg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/random_subsample_swap_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_subsample_swap_generator
// Swap pairs of a partial Fisher-Yates shuffle driven by a Lehmer generator.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  : one beat per step (restart, point_count). restart reseeds the
//             generator from the seed register and clears the position.
//   out_bus : exactly one beat per input beat (keep_index, swap_index,
//             pair_valid, last). A step with no pair returns all zeros.
//   cfg_bus : register writes (0 = max_count, 1 = seed), always ready; write
//             only while idle. max_count applies at once, seed at the next
//             restart.
// Sequence: a step with a pair runs generator multiply, Mersenne reduction,
//   range multiply and reduction on one shared multiplier (states S_GEN,
//   S_RED, S_RANGE, S_DIV, S_EMIT); in_bus.ready returns at the edge that
//   loads the result into the output register, so no new step is taken
//   before the last is through. A step without a pair goes straight to S_EMIT.
// Reset (rst_n, synchronous): generator 1, position 0, max_count 0, seed 1.
// A stalled receiver holds the output register; the core then waits with its
// finished result and in_bus.ready stays low until the beat is taken.
// ----------------------------------------------------------------------------
module random_subsample_swap_generator #(
  parameter int INDEX_BITS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  rssg_in_if.sink    in_bus,
  rssg_out_if.source out_bus,
  rssg_cfg_if.sink   cfg_bus
);

  localparam int IW = (INDEX_BITS < rssg_pkg::FIELD_BITS) ? INDEX_BITS : rssg_pkg::FIELD_BITS;

  logic [rssg_pkg::FIELD_BITS-1:0] max_count_r;
  logic [rssg_pkg::GEN_BITS-1:0]   seed_r;
  logic                            out_valid_r;
  rssg_pkg::res_t                  out_res_r;
  rssg_pkg::core_out_t             core_out;
  logic                            res_ack;
  logic                            core_ready;

  rssg_core #(
    .IW (IW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_restart (in_bus.restart),
    .in_count   (in_bus.point_count),
    .in_ready   (core_ready),
    .max_count  (max_count_r),
    .seed       (seed_r),
    .core_out   (core_out),
    .res_ack    (res_ack)
  );

  assign in_bus.ready  = core_ready;
  assign cfg_bus.ready = 1'b1;
  assign res_ack       = core_out.valid && (!out_valid_r || out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_count_r <= '0;
      seed_r      <= rssg_pkg::GEN_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        case (cfg_bus.index)
          rssg_pkg::REG_MAX_COUNT: max_count_r <= cfg_bus.data[rssg_pkg::FIELD_BITS-1:0];
          rssg_pkg::REG_SEED:      seed_r <= cfg_bus.data[rssg_pkg::GEN_BITS-1:0];
          default: ;
        endcase
      end
      if (res_ack) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_ack) begin
      out_res_r <= core_out.res;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.keep_index = out_res_r.keep_index;
  assign out_bus.swap_index = out_res_r.swap_index;
  assign out_bus.pair_valid = out_res_r.pair_valid;
  assign out_bus.last       = out_res_r.last;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("input accepted while a step is in flight");

  a_swap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.pair_valid) |-> (out_bus.swap_index >= out_bus.keep_index))
    else $error("swap index below keep index");

  a_no_pair_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && !out_bus.pair_valid) |->
      (out_bus.keep_index == '0 && out_bus.swap_index == '0 && !out_bus.last))
    else $error("empty step carries nonzero fields");

  a_last_is_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.last) |-> out_bus.pair_valid)
    else $error("last flagged without a pair");
`endif

endmodule

FILE: rtl/rssg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssg_mul
// Shared 31x16 multiplier with registered product.
// ----------------------------------------------------------------------------
module rssg_mul (
  input  logic                               clk,
  input  rssg_pkg::mul_req_t                 req,
  output logic [rssg_pkg::PROD_BITS-1:0]     prod
);

  logic [rssg_pkg::PROD_BITS-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= rssg_pkg::PROD_BITS'(req.a) * rssg_pkg::PROD_BITS'(req.b);
    end
  end

  assign prod = prod_r;

endmodule

FILE: rtl/rssg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssg_core
// Step sequencer: generator advance, Mersenne reduction, range scaling.
// ----------------------------------------------------------------------------
module rssg_core #(
  parameter int IW = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_restart,
  input  logic [rssg_pkg::FIELD_BITS-1:0]    in_count,
  output logic                               in_ready,
  input  logic [rssg_pkg::FIELD_BITS-1:0]    max_count,
  input  logic [rssg_pkg::GEN_BITS-1:0]      seed,
  output rssg_pkg::core_out_t                core_out,
  input  logic                               res_ack
);

  typedef enum logic [2:0] {S_IDLE, S_GEN, S_RED, S_RANGE, S_DIV, S_EMIT} state_t;

  localparam int GB = rssg_pkg::GEN_BITS;
  localparam int PB = rssg_pkg::PROD_BITS;

  state_t                state_r, state_nxt;
  logic [GB-1:0]         gen_r, gen_nxt;
  logic [IW-1:0]         pos_r, pos_nxt;
  logic [IW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         keep_r, keep_nxt;
  logic [IW-1:0]         swap_r, swap_nxt;
  logic                  pair_r, pair_nxt;
  logic                  last_r, last_nxt;

  rssg_pkg::mul_req_t    mreq;
  logic [PB-1:0]         prod;

  logic [IW-1:0]         keep_lim;
  logic [IW-1:0]         cnt_in;
  logic [IW-1:0]         j_in;
  logic [GB-1:0]         gen_in;
  logic [GB-1:0]         seed_ld;
  logic                  no_pair;
  logic [GB:0]           red_sum;
  logic [GB:0]           red_sub;
  logic [GB-1:0]         x_val;
  logic [GB-2:0]         div_lo;
  logic [15:0]           div_hi;
  logic [GB-1:0]         div_t;
  logic [15:0]           off;
  logic [IW:0]           j_inc;
  logic [IW-1:0]         span;

  rssg_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  always_comb begin
    keep_lim = max_count[IW-1:0];
    cnt_in   = in_count[IW-1:0];
    seed_ld  = (seed == '0 || seed == rssg_pkg::LEHMER_MOD) ? GB'(1) : seed;
    gen_in   = in_restart ? seed_ld : gen_r;
    j_in     = in_restart ? '0 : pos_r;
    no_pair  = (cnt_in == '0) || (keep_lim >= cnt_in) || (j_in >= keep_lim) ||
               (j_in >= cnt_in);

    red_sum  = {16'd0, prod[PB-1:GB]} + {1'b0, prod[GB-1:0]};
    red_sub  = red_sum - {1'b0, rssg_pkg::LEHMER_MOD};
    x_val    = (red_sum >= {1'b0, rssg_pkg::LEHMER_MOD}) ? red_sub[GB-1:0] : red_sum[GB-1:0];
    if (x_val == '0) begin
      x_val = GB'(1);
    end

    // floor(P / (2^31-2)) = a + (a + b >= 2^30-1), with P/2 = a*2^30 + b
    div_hi   = prod[PB-1:GB];
    div_lo   = prod[GB-1:1];
    div_t    = {15'd0, div_hi} + {1'b0, div_lo};
    off      = div_hi + {15'd0, (div_t >= {1'b0, rssg_pkg::HALF_RANGE})};

    j_inc    = {1'b0, pos_r} + (IW+1)'(1);
    span     = count_r - pos_r;
  end

  always_comb begin
    state_nxt = state_r;
    gen_nxt   = gen_r;
    pos_nxt   = pos_r;
    count_nxt = count_r;
    keep_nxt  = keep_r;
    swap_nxt  = swap_r;
    pair_nxt  = pair_r;
    last_nxt  = last_r;
    mreq.en   = 1'b0;
    mreq.a    = gen_r;
    mreq.b    = rssg_pkg::LEHMER_MUL;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          gen_nxt   = gen_in;
          pos_nxt   = j_in;
          count_nxt = cnt_in;
          keep_nxt  = '0;
          swap_nxt  = '0;
          pair_nxt  = 1'b0;
          last_nxt  = 1'b0;
          state_nxt = no_pair ? S_EMIT : S_GEN;
        end
      end
      S_GEN: begin
        mreq.en   = 1'b1;
        state_nxt = S_RED;
      end
      S_RED: begin
        gen_nxt   = x_val;
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        mreq.en   = 1'b1;
        mreq.a    = gen_r - GB'(1);
        mreq.b    = '0;
        mreq.b[IW-1:0] = span;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        keep_nxt  = pos_r;
        swap_nxt  = pos_r + off[IW-1:0];
        pair_nxt  = 1'b1;
        last_nxt  = (j_inc == {1'b0, keep_lim});
        pos_nxt   = j_inc[IW-1:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gen_r   <= GB'(1);
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      pos_r   <= pos_nxt;
    end
    count_r <= count_nxt;
    keep_r  <= keep_nxt;
    swap_r  <= swap_nxt;
    pair_r  <= pair_nxt;
    last_r  <= last_nxt;
  end

  always_comb begin
    in_ready                     = (state_r == S_IDLE);
    core_out.valid               = (state_r == S_EMIT);
    core_out.res                 = '0;
    core_out.res.keep_index[IW-1:0] = keep_r;
    core_out.res.swap_index[IW-1:0] = swap_r;
    core_out.res.pair_valid      = pair_r;
    core_out.res.last            = last_r;
  end

endmodule
